FILE: rtl/core/fprmmu_pkg.sv
// shared types and constants of the fifo page replacement mmu
package fprmmu_pkg;

    localparam int VA_W     = 16;
    localparam int OFF_W    = 10;
    localparam int PROC_W   = 2;
    localparam int ACT_W    = 3;
    localparam int PCNT_W   = 7;
    localparam int OUT_FR_W = 6;
    localparam int CNT_W    = 32;
    localparam int CFG_IX_W = 3;

    localparam logic [CFG_IX_W-1:0] CFG_ACTIVE = 3'd0;
    localparam logic [CFG_IX_W-1:0] CFG_PAGES0 = 3'd1;
    localparam logic [CFG_IX_W-1:0] CFG_PAGES1 = 3'd2;
    localparam logic [CFG_IX_W-1:0] CFG_PAGES2 = 3'd3;
    localparam logic [CFG_IX_W-1:0] CFG_PAGES3 = 3'd4;

    localparam logic [ACT_W-1:0]  ACTIVE_RESET = 3'd4;
    localparam logic [PCNT_W-1:0] PAGES_RESET  = 7'd16;

    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_FREE    = 2'd1,
        ST_EVICT   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PT_NOP   = 2'd0,
        PT_READ  = 2'd1,
        PT_SET   = 2'd2,
        PT_CLEAR = 2'd3
    } t_pt_cmd;

    typedef enum logic [1:0] {
        FT_NOP     = 2'd0,
        FT_READ    = 2'd1,
        FT_FILL    = 2'd2,
        FT_REPLACE = 2'd3
    } t_ft_cmd;

endpackage

FILE: rtl/core/fprmmu_addr_split.sv
// splits a virtual address into page and offset by reciprocal multiplication
module fprmmu_addr_split import fprmmu_pkg::*; #(
    parameter int PAGE_SIZE = 4
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic [VA_W-1:0]  i_va,
    input  logic             i_div,
    input  logic             i_rem,
    output logic [VA_W-1:0]  o_page,
    output logic [OFF_W-1:0] o_offset
);

    // exact for every 16 bit address with this shift and rounded-up reciprocal
    localparam int SHIFT = VA_W + $clog2(PAGE_SIZE);
    localparam longint unsigned RECIP =
        ((longint'(1) << SHIFT) + longint'(PAGE_SIZE) - 1) / longint'(PAGE_SIZE);
    localparam int RC_W = VA_W + 1;
    localparam int PR_W = VA_W + RC_W;
    localparam int RM_W = VA_W + OFF_W + 1;
    localparam logic [RC_W-1:0] RECIP_W = RC_W'(RECIP);
    localparam logic [RM_W-1:0] PSZ     = RM_W'(PAGE_SIZE);

    logic [VA_W-1:0]  r_va;
    logic [VA_W-1:0]  r_page;
    logic [OFF_W-1:0] r_offset;
    logic [PR_W-1:0]  prod;
    logic [PR_W-1:0]  quot;
    logic [RM_W-1:0]  back;
    logic [RM_W-1:0]  diff;

    assign prod = PR_W'(r_va) * PR_W'(RECIP_W);
    assign quot = prod >> SHIFT;
    assign back = RM_W'(r_page) * PSZ;
    assign diff = RM_W'(r_va) - back;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_va <= i_va;
        end
        if (i_div) begin
            r_page <= quot[VA_W-1:0];
        end
        if (i_rem) begin
            r_offset <= diff[OFF_W-1:0];
        end
    end

    assign o_page   = r_page;
    assign o_offset = r_offset;

endmodule

FILE: rtl/core/fprmmu_page_table.sv
// page table: present bits in flops, frame numbers in a single-port memory
module fprmmu_page_table import fprmmu_pkg::*; #(
    parameter int PROCESS_COUNT = 4,
    parameter int MAX_PAGES     = 16,
    parameter int FRAME_COUNT   = 8,
    localparam int DEPTH = PROCESS_COUNT * MAX_PAGES,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int FW    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_pt_cmd              i_cmd,
    input  logic [AW-1:0]        i_addr,
    input  logic [FW-1:0]        i_frame,
    output logic                 o_present,
    output logic [FW-1:0]        o_frame
);

    logic [DEPTH-1:0] r_valid;
    logic [FW-1:0]    r_mem [DEPTH];
    logic [FW-1:0]    r_rd_frame;
    logic             r_rd_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd == PT_SET) begin
            r_valid[i_addr] <= 1'b1;
        end else if (i_cmd == PT_CLEAR) begin
            r_valid[i_addr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == PT_SET) begin
            r_mem[i_addr] <= i_frame;
        end
        if (i_cmd == PT_READ) begin
            r_rd_frame   <= r_mem[i_addr];
            r_rd_present <= r_valid[i_addr];
        end
    end

    assign o_present = r_rd_present;
    assign o_frame   = r_rd_frame;

`ifndef SYNTHESIS
    a_set_marks_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == PT_SET |=> r_valid[$past(i_addr)])
        else $error("page table entry not present after a set");
`endif

endmodule

FILE: rtl/core/fprmmu_frame_table.sv
// frame table: page of each frame, fill count for free frames, fifo pointer
module fprmmu_frame_table import fprmmu_pkg::*; #(
    parameter int FRAME_COUNT = 8,
    parameter int MAX_PAGES   = 16,
    localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ft_cmd       i_cmd,
    input  logic [PW-1:0] i_page,
    output logic          o_full,
    output logic [FW-1:0] o_free_frame,
    output logic [FW-1:0] o_ptr,
    output logic [PW-1:0] o_page
);

    localparam int CW = $clog2(FRAME_COUNT + 1);

    // frames are never released, so the free ones are always the top ones
    logic [CW-1:0] r_fill;
    logic [FW-1:0] r_ptr;
    logic [PW-1:0] r_mem [FRAME_COUNT];
    logic [PW-1:0] r_rd_page;
    logic [FW-1:0] n_ptr;

    assign o_full       = (r_fill == CW'(FRAME_COUNT));
    assign o_free_frame = r_fill[FW-1:0];
    assign n_ptr = (r_ptr == FW'(FRAME_COUNT - 1)) ? '0 : r_ptr + FW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ptr  <= '0;
        end else if (i_cmd == FT_FILL) begin
            r_fill <= r_fill + CW'(1);
        end else if (i_cmd == FT_REPLACE) begin
            r_ptr <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == FT_FILL) begin
            r_mem[r_fill[FW-1:0]] <= i_page;
        end else if (i_cmd == FT_REPLACE) begin
            r_mem[r_ptr] <= i_page;
        end
        if (i_cmd == FT_READ) begin
            r_rd_page <= r_mem[r_ptr];
        end
    end

    assign o_ptr  = r_ptr;
    assign o_page = r_rd_page;

`ifndef SYNTHESIS
    a_ptr_idle_until_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_full |-> r_ptr == '0)
        else $error("fifo pointer moved before all frames were taken");
    a_no_fill_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == FT_FILL |-> !o_full)
        else $error("free frame taken with no frame free");
    a_replace_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == FT_REPLACE || i_cmd == FT_READ |-> o_full)
        else $error("eviction started with a frame still free");
`endif

endmodule

FILE: rtl/core/fifo_page_replacement_mmu_core.sv
// top level of the fifo page replacement mmu: sequencer, counters, config, result register
//
// Each transaction is one memory access (process, virtual address); exactly one result comes
// back per access, with page, offset, frame, status and the running totals. The block takes one
// access at a time. A hit, an invalid address or a fault into a free frame passes through the
// address split, the page-table look-up and the decision before the block is ready again. A
// fault with eviction then reads the page of the oldest frame and scans the registered
// processes through the single port of the page-table memory, with a read for each process
// whose page count holds the evicted page. The address split is a reciprocal multiply
// followed by a multiply-back for the offset, each registered in its own state. A finished
// result sits in an output register, so the next access is taken while it waits; a further
// result waits in the block until that register is free. Configuration writes take effect
// at once and are meant for idle periods only. No clearing pass is needed after reset.
module fifo_page_replacement_mmu_core import fprmmu_pkg::*; #(
    parameter int PAGE_SIZE     = 4,
    parameter int FRAME_COUNT   = 8,
    parameter int MAX_PAGES     = 16,
    parameter int PROCESS_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [PROC_W-1:0]   i_process_id,
    input  logic [VA_W-1:0]     i_virtual_address,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [VA_W-1:0]     o_page_number,
    output logic [OFF_W-1:0]    o_page_offset,
    output logic [OUT_FR_W-1:0] o_frame_number,
    output logic [OUT_FR_W-1:0] o_evicted_page,
    output logic [CNT_W-1:0]    o_access_count,
    output logic [CNT_W-1:0]    o_fault_count,
    output logic [CNT_W-1:0]    o_hit_count,
    input  logic                i_cfg_we,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [PCNT_W-1:0]   i_cfg_data
);

    localparam int DEPTH = PROCESS_COUNT * MAX_PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DIV      = 10'b00_0000_0010,
        S_REM      = 10'b00_0000_0100,
        S_LOOK     = 10'b00_0000_1000,
        S_DECIDE   = 10'b00_0001_0000,
        S_EVRD     = 10'b00_0010_0000,
        S_SCAN_RD  = 10'b00_0100_0000,
        S_SCAN_CHK = 10'b00_1000_0000,
        S_COMMIT   = 10'b01_0000_0000,
        S_OUT      = 10'b10_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [PROC_W-1:0]    r_proc;
    logic                 r_in_range;
    logic [AW-1:0]        r_slot;
    t_status              r_status;
    logic [FW-1:0]        r_frame;
    logic [PW-1:0]        r_evicted;
    logic [ACT_W-1:0]     r_scan_p;
    logic [AW-1:0]        r_scan_addr;
    logic [CNT_W-1:0]     r_access, r_fault, r_hit;
    logic [ACT_W-1:0]     r_active;
    logic [PCNT_W-1:0]    r_pages [4];

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [VA_W-1:0]      r_out_page;
    logic [OFF_W-1:0]     r_out_offset;
    logic [OUT_FR_W-1:0]  r_out_frame;
    logic [OUT_FR_W-1:0]  r_out_evicted;
    logic [CNT_W-1:0]     r_out_access, r_out_fault, r_out_hit;

    logic [PCNT_W-1:0]    pages_lim [4];
    logic [ACT_W-1:0]     act;
    logic                 split_load, split_div, split_rem;
    logic [VA_W-1:0]      page;
    logic [OFF_W-1:0]     offset;
    t_pt_cmd              pt_cmd;
    logic [AW-1:0]        pt_addr;
    logic [FW-1:0]        pt_wr_frame;
    logic                 pt_present;
    logic [FW-1:0]        pt_rd_frame;
    t_ft_cmd              ft_cmd;
    logic                 ft_full;
    logic [FW-1:0]        ft_free;
    logic [FW-1:0]        ft_ptr;
    logic [PW-1:0]        ft_page;
    logic [AW-1:0]        scan_addr;
    logic                 scan_hit_range;
    logic                 out_load;
    logic                 accept;

    // page count seen by each process, clamped, zero beyond the built processes
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (i >= PROCESS_COUNT) begin
                pages_lim[i] = '0;
            end else if (r_pages[i] > PCNT_W'(MAX_PAGES)) begin
                pages_lim[i] = PCNT_W'(MAX_PAGES);
            end else begin
                pages_lim[i] = r_pages[i];
            end
        end
    end

    assign act = (r_active > ACT_W'(PROCESS_COUNT)) ? ACT_W'(PROCESS_COUNT) : r_active;

    // shared compare of the scan: evicted page within this process's page count
    assign scan_hit_range = PCNT_W'(r_evicted) < pages_lim[r_scan_p[PROC_W-1:0]];
    assign scan_addr      = AW'(int'(r_scan_p) * MAX_PAGES + int'(r_evicted));

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        split_load  = 1'b0;
        split_div   = 1'b0;
        split_rem   = 1'b0;
        pt_cmd      = PT_NOP;
        pt_addr     = r_slot;
        pt_wr_frame = r_frame;
        ft_cmd      = FT_NOP;
        unique case (r_state)
            S_IDLE: begin
                split_load = accept;
                if (accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                split_div = 1'b1;
                n_state   = S_REM;
            end
            S_REM: begin
                split_rem = 1'b1;
                n_state   = S_LOOK;
            end
            S_LOOK: begin
                pt_cmd  = PT_READ;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!r_in_range || pt_present) begin
                    n_state = S_OUT;
                end else if (!ft_full) begin
                    ft_cmd      = FT_FILL;
                    pt_cmd      = PT_SET;
                    pt_wr_frame = ft_free;
                    n_state     = S_OUT;
                end else begin
                    ft_cmd  = FT_READ;
                    n_state = S_EVRD;
                end
            end
            S_EVRD: begin
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (r_scan_p == act) begin
                    n_state = S_COMMIT;
                end else if (scan_hit_range) begin
                    pt_cmd  = PT_READ;
                    pt_addr = scan_addr;
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (pt_present && pt_rd_frame == r_frame) begin
                    pt_cmd  = PT_CLEAR;
                    pt_addr = r_scan_addr;
                end
                n_state = S_SCAN_RD;
            end
            S_COMMIT: begin
                ft_cmd  = FT_REPLACE;
                pt_cmd  = PT_SET;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_access <= '0;
            r_fault  <= '0;
            r_hit    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECIDE) begin
                r_access <= r_access + CNT_W'(1);
                if (r_in_range && pt_present) begin
                    r_hit <= r_hit + CNT_W'(1);
                end
                if (r_in_range && !pt_present) begin
                    r_fault <= r_fault + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_proc <= i_process_id;
        end
        if (r_state == S_REM) begin
            r_in_range <= page < VA_W'(pages_lim[r_proc]);
            r_slot     <= AW'(int'(r_proc) * MAX_PAGES + int'(page));
        end
        if (r_state == S_DECIDE) begin
            r_evicted <= '0;
            if (!r_in_range) begin
                r_status <= ST_INVALID;
                r_frame  <= '0;
            end else if (pt_present) begin
                r_status <= ST_HIT;
                r_frame  <= pt_rd_frame;
            end else if (!ft_full) begin
                r_status <= ST_FREE;
                r_frame  <= ft_free;
            end else begin
                r_status <= ST_EVICT;
                r_frame  <= ft_ptr;
            end
        end
        if (r_state == S_EVRD) begin
            r_evicted <= ft_page;
        end
        if (r_state == S_SCAN_RD) begin
            r_scan_addr <= scan_addr;
        end
    end

    // scan counter steps past a process once it is read, or at once when out of range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_p <= '0;
        end else if (r_state == S_EVRD) begin
            r_scan_p <= '0;
        end else if ((r_state == S_SCAN_RD && r_scan_p != act && !scan_hit_range)
                     || r_state == S_SCAN_CHK) begin
            r_scan_p <= r_scan_p + ACT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
            for (int i = 0; i < 4; i++) begin
                r_pages[i] <= PAGES_RESET;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACTIVE: r_active   <= i_cfg_data[ACT_W-1:0];
                CFG_PAGES0: r_pages[0] <= i_cfg_data;
                CFG_PAGES1: r_pages[1] <= i_cfg_data;
                CFG_PAGES2: r_pages[2] <= i_cfg_data;
                CFG_PAGES3: r_pages[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status  <= r_status;
            r_out_page    <= page;
            r_out_offset  <= offset;
            r_out_frame   <= OUT_FR_W'(r_frame);
            r_out_evicted <= OUT_FR_W'(r_evicted);
            r_out_access  <= r_access;
            r_out_fault   <= r_fault;
            r_out_hit     <= r_hit;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_page_number  = r_out_page;
    assign o_page_offset  = r_out_offset;
    assign o_frame_number = r_out_frame;
    assign o_evicted_page = r_out_evicted;
    assign o_access_count = r_out_access;
    assign o_fault_count  = r_out_fault;
    assign o_hit_count    = r_out_hit;

    fprmmu_addr_split #(
        .PAGE_SIZE (PAGE_SIZE)
    ) u_split (
        .i_clk    (i_clk),
        .i_load   (split_load),
        .i_va     (i_virtual_address),
        .i_div    (split_div),
        .i_rem    (split_rem),
        .o_page   (page),
        .o_offset (offset)
    );

    fprmmu_page_table #(
        .PROCESS_COUNT (PROCESS_COUNT),
        .MAX_PAGES     (MAX_PAGES),
        .FRAME_COUNT   (FRAME_COUNT)
    ) u_pt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (pt_cmd),
        .i_addr    (pt_addr),
        .i_frame   (pt_wr_frame),
        .o_present (pt_present),
        .o_frame   (pt_rd_frame)
    );

    fprmmu_frame_table #(
        .FRAME_COUNT (FRAME_COUNT),
        .MAX_PAGES   (MAX_PAGES)
    ) u_ft (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ft_cmd),
        .i_page       (page[PW-1:0]),
        .o_full       (ft_full),
        .o_free_frame (ft_free),
        .o_ptr        (ft_ptr),
        .o_page       (ft_page)
    );

`ifndef SYNTHESIS
    a_access_counts_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DECIDE |=> r_access == $past(r_access) + CNT_W'(1))
        else $error("access total did not step once per transaction");
    a_invalid_zero_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && o_status == ST_INVALID
        |-> o_frame_number == '0 && o_evicted_page == '0)
        else $error("invalid access reported a frame or evicted page");
`endif

endmodule

FILE: tb/sv/testbench.sv
// testbench for the fifo page replacement mmu: access driver, result monitor and translation predictor
`timescale 1ns / 1ps

module testbench;
    import fprmmu_pkg::*;

    localparam int PAGE_SIZE     = 4;
    localparam int FRAME_COUNT   = 8;
    localparam int MAX_PAGES     = 16;
    localparam int PROCESS_COUNT = 4;
    localparam int DRAIN_CYCLES  = 24;

    typedef struct packed {
        logic [PROC_W-1:0] proc;
        logic [VA_W-1:0]   va;
    } t_access;

    typedef struct packed {
        t_status             status;
        logic [VA_W-1:0]     page;
        logic [OFF_W-1:0]    offset;
        logic [OUT_FR_W-1:0] frame;
        logic [OUT_FR_W-1:0] evicted;
        logic [CNT_W-1:0]    accesses;
        logic [CNT_W-1:0]    faults;
        logic [CNT_W-1:0]    hits;
    } t_access_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                o_in_ready;
    logic [PROC_W-1:0]   process_id = '0;
    logic [VA_W-1:0]     virtual_address = '0;
    logic                o_out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          o_status;
    logic [VA_W-1:0]     o_page_number;
    logic [OFF_W-1:0]    o_page_offset;
    logic [OUT_FR_W-1:0] o_frame_number;
    logic [OUT_FR_W-1:0] o_evicted_page;
    logic [CNT_W-1:0]    o_access_count;
    logic [CNT_W-1:0]    o_fault_count;
    logic [CNT_W-1:0]    o_hit_count;
    logic                cfg_we = 1'b0;
    logic [CFG_IX_W-1:0] cfg_index = '0;
    logic [PCNT_W-1:0]   cfg_data = '0;

    fifo_page_replacement_mmu_core #(
        .PAGE_SIZE     (PAGE_SIZE),
        .FRAME_COUNT   (FRAME_COUNT),
        .MAX_PAGES     (MAX_PAGES),
        .PROCESS_COUNT (PROCESS_COUNT)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_process_id      (process_id),
        .i_virtual_address (virtual_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_status          (o_status),
        .o_page_number     (o_page_number),
        .o_page_offset     (o_page_offset),
        .o_frame_number    (o_frame_number),
        .o_evicted_page    (o_evicted_page),
        .o_access_count    (o_access_count),
        .o_fault_count     (o_fault_count),
        .o_hit_count       (o_hit_count),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    // predictor state
    logic                mdl_pt_present [0:PROCESS_COUNT*MAX_PAGES-1];
    logic [5:0]          mdl_pt_frame   [0:PROCESS_COUNT*MAX_PAGES-1];
    logic                mdl_ft_used    [0:FRAME_COUNT-1];
    logic [VA_W-1:0]     mdl_ft_page    [0:FRAME_COUNT-1];
    int                  mdl_fifo_ptr;
    logic [CNT_W-1:0]    mdl_accesses;
    logic [CNT_W-1:0]    mdl_faults;
    logic [CNT_W-1:0]    mdl_hits;
    logic [ACT_W-1:0]    mdl_active;
    logic [PCNT_W-1:0]   mdl_pages [0:3];

    t_access             pending_accesses [$];
    t_access_result      expected_results [$];

    int errors = 0;
    int n_checked = 0;
    int n_configs = 1;
    int n_by_status [0:3] = '{0, 0, 0, 0};
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pages_of_process(input int proc);
        int n;
        if (proc >= PROCESS_COUNT)
            return 0;
        n = mdl_pages[proc];
        return (n > MAX_PAGES) ? MAX_PAGES : n;
    endfunction

    function automatic void reset_translation();
        for (int i = 0; i < PROCESS_COUNT*MAX_PAGES; i++) begin
            mdl_pt_present[i] = 1'b0;
            mdl_pt_frame[i]   = '0;
        end
        for (int i = 0; i < FRAME_COUNT; i++) begin
            mdl_ft_used[i] = 1'b0;
            mdl_ft_page[i] = '0;
        end
        mdl_fifo_ptr = 0;
        mdl_accesses = '0;
        mdl_faults   = '0;
        mdl_hits     = '0;
        mdl_active   = ACTIVE_RESET;
        for (int i = 0; i < 4; i++)
            mdl_pages[i] = PAGES_RESET;
    endfunction

    function automatic t_access_result translate_access(input t_access acc);
        t_access_result r;
        int page;
        int slot;
        int f;
        int act;
        int s;
        int victim;
        bit placed;
        page   = acc.va / PAGE_SIZE;
        r.status  = ST_INVALID;
        r.page    = VA_W'(page);
        r.offset  = OFF_W'(acc.va % PAGE_SIZE);
        r.frame   = '0;
        r.evicted = '0;
        mdl_accesses = mdl_accesses + 1;
        if (page < pages_of_process(acc.proc)) begin
            slot = acc.proc * MAX_PAGES + page;
            if (mdl_pt_present[slot]) begin
                mdl_hits = mdl_hits + 1;
                r.status = ST_HIT;
                r.frame  = mdl_pt_frame[slot];
            end else begin
                mdl_faults = mdl_faults + 1;
                placed = 1'b0;
                f = 0;
                for (int i = 0; i < FRAME_COUNT && !placed; i++) begin
                    if (!mdl_ft_used[i]) begin
                        mdl_ft_used[i] = 1'b1;
                        mdl_ft_page[i] = VA_W'(page);
                        placed = 1'b1;
                        f = i;
                    end
                end
                if (placed) begin
                    r.status = ST_FREE;
                end else begin
                    f = mdl_fifo_ptr % FRAME_COUNT;
                    victim = mdl_ft_page[f];
                    act = (mdl_active > PROCESS_COUNT) ? PROCESS_COUNT : mdl_active;
                    // unmap the victim only where it still points at this frame
                    for (int p = 0; p < act; p++) begin
                        if (victim < pages_of_process(p)) begin
                            s = p * MAX_PAGES + victim;
                            if (mdl_pt_present[s] && mdl_pt_frame[s] == f) begin
                                mdl_pt_present[s] = 1'b0;
                                mdl_pt_frame[s]   = '0;
                            end
                        end
                    end
                    mdl_ft_page[f] = VA_W'(page);
                    mdl_fifo_ptr = (f + 1) % FRAME_COUNT;
                    r.status  = ST_EVICT;
                    r.evicted = OUT_FR_W'(victim);
                end
                mdl_pt_present[slot] = 1'b1;
                mdl_pt_frame[slot]   = 6'(f);
                r.frame = OUT_FR_W'(f);
            end
        end
        r.accesses = mdl_accesses;
        r.faults   = mdl_faults;
        r.hits     = mdl_hits;
        return r;
    endfunction

    // driver: bursts of transactions with random gaps in between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                expected_results = {expected_results,
                                    translate_access({process_id, virtual_address})};
            if (in_valid && !o_in_ready) begin
                // hold the payload until accepted
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
                t_access nxt;
                nxt = pending_accesses.pop_front();
                process_id      <= nxt.proc;
                virtual_address <= nxt.va;
                in_valid        <= 1'b1;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 10);
                    gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 20);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure, switching between a few stall patterns
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(8, 64);
            end
            stall_left = stall_left - 1;
            case (stall_mode)
                0: begin
                    out_ready <= 1'b1;
                end
                1: begin
                    out_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    out_ready <= ($urandom_range(0, 7) == 0);
                end
                default: begin
                    out_ready <= (stall_left % 5 != 0);
                end
            endcase
        end
    end

    task automatic check_field(input string name, input logic [CNT_W-1:0] exp_val,
                               input logic [CNT_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
        end
    endtask

    // monitor: every result transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with no access outstanding");
                errors++;
            end else begin
                t_access_result e;
                e = expected_results.pop_front();
                check_field("status",       CNT_W'(e.status),   CNT_W'(o_status));
                check_field("page_number",  CNT_W'(e.page),     CNT_W'(o_page_number));
                check_field("page_offset",  CNT_W'(e.offset),   CNT_W'(o_page_offset));
                check_field("frame_number", CNT_W'(e.frame),    CNT_W'(o_frame_number));
                check_field("evicted_page", CNT_W'(e.evicted),  CNT_W'(o_evicted_page));
                check_field("access_count", e.accesses,         o_access_count);
                check_field("fault_count",  e.faults,           o_fault_count);
                check_field("hit_count",    e.hits,             o_hit_count);
                n_checked++;
                n_by_status[e.status]++;
            end
        end
    end

    task automatic push_access(input int proc, input int va);
        t_access a;
        a.proc = PROC_W'(proc);
        a.va   = VA_W'(va);
        pending_accesses = {pending_accesses, a};
    endtask

    task automatic push_random(input int count);
        int r;
        int va;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            // mostly valid pages around the page count boundary, some anywhere
            if (r < 80)
                va = $urandom_range(0, 71);
            else if (r < 90)
                va = $urandom_range(0, 255);
            else
                va = $urandom() & 16'hFFFF;
            push_access($urandom_range(0, 3), va);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_accesses.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input int value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= PCNT_W'(value);
        if (idx == CFG_ACTIVE)
            mdl_active = ACT_W'(value);
        else
            mdl_pages[idx - CFG_PAGES0] = PCNT_W'(value);
    endtask

    task automatic run_phase(input int act, input int p0, input int p1, input int p2,
                             input int p3, input int count);
        wait_idle();
        write_reg(CFG_ACTIVE, act);
        write_reg(CFG_PAGES0, p0);
        write_reg(CFG_PAGES1, p1);
        write_reg(CFG_PAGES2, p2);
        write_reg(CFG_PAGES3, p3);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        n_configs++;
        @(negedge i_clk);
        push_random(count);
    endtask

    initial begin
        reset_translation();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: fill every frame, then walk the fifo pointer
        push_access(0, 0);
        push_access(0, 3);
        push_access(1, 0);
        push_access(0, 16'hFFFF);
        push_access(0, 64);
        push_access(3, 63);
        push_access(2, 4);
        push_access(2, 8);
        push_access(2, 12);
        push_access(2, 16);
        push_access(2, 20);
        // page zero evicted while another process maps page zero to another frame
        push_access(2, 24);
        push_access(1, 1);
        push_access(0, 2);
        push_access(1, 2);
        push_access(3, 60);
        push_access(3, 16'hAAAA);
        push_access(1, 16'h5555);
        push_access(2, 62);
        push_access(0, 0);
        push_random(150);

        // no process scanned on eviction, clamped and zero page counts
        run_phase(0, 64, 127, 0, 5, 150);
        // active count over the process count
        run_phase(7, 3, 16, 1, 100, 150);
        // unregistered accessors keep their mappings
        run_phase(1, 16, 8, 16, 0, 150);
        // shrunken page counts leave stale entries behind
        run_phase(2, 2, 2, 2, 2, 100);
        run_phase(4, 16, 16, 16, 16, 150);
        run_phase(5, 10, 12, 64, 16, 100);

        wait_idle();
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        $display("checked %0d access transactions under %0d register settings",
                 n_checked, n_configs);
        $display("hits %0d, free-frame faults %0d, evictions %0d, invalid %0d",
                 n_by_status[ST_HIT], n_by_status[ST_FREE], n_by_status[ST_EVICT],
                 n_by_status[ST_INVALID]);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/fprmmu_pkg.sv
rtl/core/fprmmu_addr_split.sv
rtl/core/fprmmu_page_table.sv
rtl/core/fprmmu_frame_table.sv
rtl/core/fifo_page_replacement_mmu_core.sv
tb/sv/testbench.sv
